### design/lav_pkg.sv
// Shared types and constants for the look-at view matrix pipeline.
package lav_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ELEM_W        = 32;
    // Normalization scales the largest magnitude into [2^(NRM_BITS-1), 2^NRM_BITS).
    localparam int NRM_BITS      = 30;

    typedef logic signed [ELEM_W-1:0] elem_t;

    typedef struct packed {
        elem_t x;
        elem_t y;
        elem_t z;
    } vec3_t;

    typedef struct packed {
        elem_t eye_x;
        elem_t eye_y;
        elem_t eye_z;
        elem_t target_x;
        elem_t target_y;
        elem_t target_z;
        elem_t upward_x;
        elem_t upward_y;
        elem_t upward_z;
    } lav_in_t;

    typedef struct packed {
        elem_t      elem_0;
        elem_t      elem_1;
        elem_t      elem_2;
        elem_t      elem_3;
        logic [1:0] row_index;
        logic       degenerate;
        logic       last_row;
    } lav_out_t;

    typedef enum logic [1:0] {
        ROW_X = 2'd0,
        ROW_Y = 2'd1,
        ROW_Z = 2'd2,
        ROW_W = 2'd3
    } row_t;

    // Data carried alongside the first normalization.
    typedef struct packed {
        vec3_t eye;
        vec3_t up;
    } side1_t;

    // Data carried through the first cross product and second normalization.
    typedef struct packed {
        vec3_t eye;
        vec3_t z_ax;
        logic  deg;
    } side2_t;

    // Data carried through the second cross product and third normalization.
    typedef struct packed {
        vec3_t eye;
        vec3_t z_ax;
        vec3_t x_ax;
        logic  deg;
    } side3_t;

    typedef struct packed {
        vec3_t x_ax;
        vec3_t y_ax;
        vec3_t z_ax;
        vec3_t eye;
        logic  deg;
    } axes_t;

    typedef struct packed {
        vec3_t x_ax;
        vec3_t y_ax;
        vec3_t z_ax;
        elem_t tx;
        elem_t ty;
        elem_t tz;
        logic  deg;
    } mat_t;

endpackage

### design/lav_norm.sv
// Pipelined vector normalization: scale, sum of squares, square root, divide.
module lav_norm #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF,
    parameter int IN_W      = 33,
    parameter int SIDE_W    = 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [IN_W-1:0]  in_vec [3],
    input  logic [SIDE_W-1:0]       in_side,
    output logic                    out_valid,
    output lav_pkg::vec3_t          out_vec,
    output logic                    out_zero,
    output logic [SIDE_W-1:0]       out_side
);

    localparam int NB       = lav_pkg::NRM_BITS;
    localparam int LEN_W    = $clog2(IN_W + 1);
    localparam int SQ_STEPS = 32;
    localparam int W64      = 64;
    localparam int QW       = FRAC_BITS + 1;
    localparam int EW       = lav_pkg::ELEM_W;
    localparam int CW       = SIDE_W + 4 + 3 * NB;
    localparam int DW       = SIDE_W + 4;

    // Stage A: magnitudes and signs.
    logic              a_valid_reg;
    logic [IN_W-1:0]   a_mag_reg [3];
    logic [IN_W-1:0]   a_mag_next [3];
    logic [2:0]        a_neg_reg;
    logic [2:0]        a_neg_next;
    logic [SIDE_W-1:0] a_side_reg;

    // Stage B: largest magnitude.
    logic              b_valid_reg;
    logic [IN_W-1:0]   b_mag_reg [3];
    logic [IN_W-1:0]   b_max_reg;
    logic [IN_W-1:0]   b_max_next;
    logic [2:0]        b_neg_reg;
    logic [SIDE_W-1:0] b_side_reg;

    // Stage C: bit length of the largest magnitude.
    logic              c_valid_reg;
    logic [IN_W-1:0]   c_mag_reg [3];
    logic [LEN_W-1:0]  c_len_reg;
    logic [LEN_W-1:0]  c_len_next;
    logic              c_zero_reg;
    logic [2:0]        c_neg_reg;
    logic [SIDE_W-1:0] c_side_reg;

    // Stage D: scaled magnitudes.
    logic              d_valid_reg;
    logic [NB-1:0]     d_mg_reg [3];
    logic [NB-1:0]     d_mg_next [3];
    logic              d_zero_reg;
    logic [2:0]        d_neg_reg;
    logic [SIDE_W-1:0] d_side_reg;

    // Stage E: squares.
    logic              e_valid_reg;
    logic [2*NB-1:0]   e_sq_reg [3];
    logic [NB-1:0]     e_mg_reg [3];
    logic              e_zero_reg;
    logic [2:0]        e_neg_reg;
    logic [SIDE_W-1:0] e_side_reg;

    // Square root stages; index 0 holds the sum of squares.
    logic [W64-1:0]    sx_reg [SQ_STEPS+1];
    logic [W64-1:0]    sr_reg [SQ_STEPS+1];
    logic              sv_reg [SQ_STEPS+1];
    logic [CW-1:0]     sc_reg [SQ_STEPS+1];

    // Division stages; index 0 holds the rounded numerators.
    logic [W64-1:0]    dv_rem_reg [QW+1][3];
    logic [QW-1:0]     dv_q_reg [QW+1][3];
    logic [W64-1:0]    dv_s_reg [QW+1];
    logic              dv_v_reg [QW+1];
    logic [DW-1:0]     dv_c_reg [QW+1];

    logic [CW-1:0]     sq_c;
    logic [W64-1:0]    sq_s;
    logic [DW-1:0]     dq_c;
    lav_pkg::elem_t    fin [3];

    logic              out_valid_reg;
    lav_pkg::vec3_t    out_vec_reg;
    logic              out_zero_reg;
    logic [SIDE_W-1:0] out_side_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_neg_next[i] = in_vec[i][IN_W-1];
            a_mag_next[i] = a_neg_next[i] ? (IN_W'(0) - $unsigned(in_vec[i]))
                                          : $unsigned(in_vec[i]);
        end
    end

    always_comb begin
        b_max_next = a_mag_reg[0];
        if (a_mag_reg[1] > b_max_next) begin
            b_max_next = a_mag_reg[1];
        end
        if (a_mag_reg[2] > b_max_next) begin
            b_max_next = a_mag_reg[2];
        end
    end

    always_comb begin
        c_len_next = '0;
        for (int i = 0; i < IN_W; i++) begin
            if (b_max_reg[i]) begin
                c_len_next = LEN_W'(i + 1);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (c_len_reg > LEN_W'(NB)) begin
                d_mg_next[i] = NB'(c_mag_reg[i] >> (c_len_reg - LEN_W'(NB)));
            end else begin
                d_mg_next[i] = NB'(c_mag_reg[i] << (LEN_W'(NB) - c_len_reg));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            sv_reg[0]   <= 1'b0;
            dv_v_reg[0] <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            sv_reg[0]   <= e_valid_reg;
            dv_v_reg[0] <= sv_reg[SQ_STEPS];
        end
    end

    assign sq_c = sc_reg[SQ_STEPS];
    assign sq_s = sr_reg[SQ_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            a_mag_reg  <= a_mag_next;
            a_neg_reg  <= a_neg_next;
            a_side_reg <= in_side;

            b_mag_reg  <= a_mag_reg;
            b_max_reg  <= b_max_next;
            b_neg_reg  <= a_neg_reg;
            b_side_reg <= a_side_reg;

            c_mag_reg  <= b_mag_reg;
            c_len_reg  <= c_len_next;
            c_zero_reg <= (b_max_reg == '0);
            c_neg_reg  <= b_neg_reg;
            c_side_reg <= b_side_reg;

            d_mg_reg   <= d_mg_next;
            d_zero_reg <= c_zero_reg;
            d_neg_reg  <= c_neg_reg;
            d_side_reg <= c_side_reg;

            for (int i = 0; i < 3; i++) begin
                e_sq_reg[i] <= (2*NB)'(d_mg_reg[i]) * (2*NB)'(d_mg_reg[i]);
            end
            e_mg_reg   <= d_mg_reg;
            e_zero_reg <= d_zero_reg;
            e_neg_reg  <= d_neg_reg;
            e_side_reg <= d_side_reg;

            sx_reg[0] <= W64'(e_sq_reg[0]) + W64'(e_sq_reg[1]) + W64'(e_sq_reg[2]);
            sr_reg[0] <= '0;
            sc_reg[0] <= {e_side_reg, e_zero_reg, e_neg_reg,
                          e_mg_reg[2], e_mg_reg[1], e_mg_reg[0]};

            dv_s_reg[0] <= sq_s;
            for (int i = 0; i < 3; i++) begin
                dv_rem_reg[0][i] <= (W64'(sq_c[i*NB +: NB]) << FRAC_BITS) + (sq_s >> 1);
                dv_q_reg[0][i]   <= '0;
            end
            dv_c_reg[0] <= sq_c[CW-1 -: DW];
        end
    end

    // One bit of the integer square root per stage.
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [W64-1:0] SQ_BIT = W64'(1) << (62 - 2 * k);
        logic [W64-1:0] trial;
        logic           take;

        assign trial = sr_reg[k] + SQ_BIT;
        assign take  = (sx_reg[k] >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sv_reg[k+1] <= 1'b0;
            end else if (en) begin
                sv_reg[k+1] <= sv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sx_reg[k+1] <= take ? (sx_reg[k] - trial) : sx_reg[k];
                sr_reg[k+1] <= take ? ((sr_reg[k] >> 1) + SQ_BIT) : (sr_reg[k] >> 1);
                sc_reg[k+1] <= sc_reg[k];
            end
        end
    end

    // One quotient bit per stage, three lanes sharing the divisor.
    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int QB = QW - 1 - j;
        logic [W64-1:0] dvsr;

        assign dvsr = dv_s_reg[j] << QB;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[j+1] <= 1'b0;
            end else if (en) begin
                dv_v_reg[j+1] <= dv_v_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    if (dv_rem_reg[j][i] >= dvsr) begin
                        dv_rem_reg[j+1][i] <= dv_rem_reg[j][i] - dvsr;
                        dv_q_reg[j+1][i]   <= dv_q_reg[j][i] | (QW'(1) << QB);
                    end else begin
                        dv_rem_reg[j+1][i] <= dv_rem_reg[j][i];
                        dv_q_reg[j+1][i]   <= dv_q_reg[j][i];
                    end
                end
                dv_s_reg[j+1] <= dv_s_reg[j];
                dv_c_reg[j+1] <= dv_c_reg[j];
            end
        end
    end

    assign dq_c = dv_c_reg[QW];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (dq_c[3]) begin
                fin[i] = '0;
            end else if (dq_c[i]) begin
                fin[i] = EW'(0) - EW'(dv_q_reg[QW][i]);
            end else begin
                fin[i] = EW'(dv_q_reg[QW][i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv_v_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_vec_reg.x <= fin[0];
            out_vec_reg.y <= fin[1];
            out_vec_reg.z <= fin[2];
            out_zero_reg  <= dq_c[3];
            out_side_reg  <= dq_c[DW-1 -: SIDE_W];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_vec   = out_vec_reg;
    assign out_zero  = out_zero_reg;
    assign out_side  = out_side_reg;

endmodule

### design/lav_xprod.sv
// Two-stage exact cross product: partial products, then differences.
module lav_xprod #(
    parameter int A_W    = 32,
    parameter int B_W    = 32,
    parameter int SIDE_W = 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [A_W-1:0]     a [3],
    input  logic signed [B_W-1:0]     b [3],
    input  logic [SIDE_W-1:0]         in_side,
    output logic                      out_valid,
    output logic signed [A_W+B_W:0]   out_vec [3],
    output logic [SIDE_W-1:0]         out_side
);

    localparam int PW = A_W + B_W;

    logic                  p_valid_reg;
    logic signed [PW-1:0]  p_reg [6];
    logic [SIDE_W-1:0]     p_side_reg;

    logic                  o_valid_reg;
    logic signed [PW:0]    o_vec_reg [3];
    logic [SIDE_W-1:0]     o_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= in_valid;
            o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0]   <= PW'(a[1]) * PW'(b[2]);
            p_reg[1]   <= PW'(a[2]) * PW'(b[1]);
            p_reg[2]   <= PW'(a[2]) * PW'(b[0]);
            p_reg[3]   <= PW'(a[0]) * PW'(b[2]);
            p_reg[4]   <= PW'(a[0]) * PW'(b[1]);
            p_reg[5]   <= PW'(a[1]) * PW'(b[0]);
            p_side_reg <= in_side;

            o_vec_reg[0] <= (PW+1)'(p_reg[0]) - (PW+1)'(p_reg[1]);
            o_vec_reg[1] <= (PW+1)'(p_reg[2]) - (PW+1)'(p_reg[3]);
            o_vec_reg[2] <= (PW+1)'(p_reg[4]) - (PW+1)'(p_reg[5]);
            o_side_reg   <= p_side_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_vec   = o_vec_reg;
    assign out_side  = o_side_reg;

endmodule

### design/lav_xlate.sv
// Translation column: axis dot eye, rounded, negated and saturated, in three stages.
module lav_xlate #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  lav_pkg::axes_t in_axes,
    output logic           out_valid,
    output lav_pkg::mat_t  out_mat
);

    localparam int PW = 2 * lav_pkg::ELEM_W;
    localparam int DW = PW + 2;
    localparam int EW = lav_pkg::ELEM_W;

    lav_pkg::elem_t        ax_e [3][3];
    lav_pkg::elem_t        eye_e [3];

    logic                  p_valid_reg;
    logic signed [PW-1:0]  p_reg [3][3];
    lav_pkg::axes_t        p_axes_reg;

    logic                  s_valid_reg;
    logic signed [DW-1:0]  dot_reg [3];
    lav_pkg::axes_t        s_axes_reg;

    logic                  o_valid_reg;
    lav_pkg::elem_t        tr_reg [3];
    lav_pkg::elem_t        tr_next [3];
    lav_pkg::axes_t        o_axes_reg;

    logic [DW-1:0]         mag [3];
    logic [DW-1:0]         rnd [3];

    assign ax_e[0][0] = in_axes.x_ax.x;
    assign ax_e[0][1] = in_axes.x_ax.y;
    assign ax_e[0][2] = in_axes.x_ax.z;
    assign ax_e[1][0] = in_axes.y_ax.x;
    assign ax_e[1][1] = in_axes.y_ax.y;
    assign ax_e[1][2] = in_axes.y_ax.z;
    assign ax_e[2][0] = in_axes.z_ax.x;
    assign ax_e[2][1] = in_axes.z_ax.y;
    assign ax_e[2][2] = in_axes.z_ax.z;
    assign eye_e[0]   = in_axes.eye.x;
    assign eye_e[1]   = in_axes.eye.y;
    assign eye_e[2]   = in_axes.eye.z;

    // Magnitude is rounded half away from zero before the sign is flipped.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            mag[r] = dot_reg[r][DW-1] ? (DW'(0) - $unsigned(dot_reg[r]))
                                      : $unsigned(dot_reg[r]);
            rnd[r] = (mag[r] + (DW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (dot_reg[r][DW-1]) begin
                if (rnd[r] > ((DW'(1) << (EW - 1)) - DW'(1))) begin
                    tr_next[r] = {1'b0, {(EW-1){1'b1}}};
                end else begin
                    tr_next[r] = EW'(rnd[r]);
                end
            end else begin
                if (rnd[r] > (DW'(1) << (EW - 1))) begin
                    tr_next[r] = {1'b1, {(EW-1){1'b0}}};
                end else begin
                    tr_next[r] = EW'(0) - EW'(rnd[r]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= in_valid;
            s_valid_reg <= p_valid_reg;
            o_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    p_reg[r][c] <= PW'(ax_e[r][c]) * PW'(eye_e[c]);
                end
                dot_reg[r] <= DW'(p_reg[r][0]) + DW'(p_reg[r][1]) + DW'(p_reg[r][2]);
            end
            p_axes_reg <= in_axes;
            s_axes_reg <= p_axes_reg;
            o_axes_reg <= s_axes_reg;
            tr_reg     <= tr_next;
        end
    end

    assign out_valid    = o_valid_reg;
    assign out_mat.x_ax = o_axes_reg.x_ax;
    assign out_mat.y_ax = o_axes_reg.y_ax;
    assign out_mat.z_ax = o_axes_reg.z_ax;
    assign out_mat.tx   = tr_reg[0];
    assign out_mat.ty   = tr_reg[1];
    assign out_mat.tz   = tr_reg[2];
    assign out_mat.deg  = o_axes_reg.deg;

endmodule

### design/lav_rows.sv
// Output stage: holds one finished matrix and sends it as four row transactions.
module lav_rows #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pipe_valid,
    input  lav_pkg::mat_t     pipe_mat,
    output logic              en,
    output logic              m_valid,
    output lav_pkg::lav_out_t m_data,
    input  logic              m_ready
);

    localparam int EW = lav_pkg::ELEM_W;

    logic            valid_reg;
    lav_pkg::row_t   row_reg;
    lav_pkg::mat_t   mat_reg;
    lav_pkg::elem_t  one;

    assign one = EW'(1) << FRAC_BITS;

    // The pipeline moves whenever this stage is empty or its final row leaves.
    assign en = !valid_reg || (m_ready && (row_reg == lav_pkg::ROW_W));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            row_reg   <= lav_pkg::ROW_X;
        end else if (en) begin
            valid_reg <= pipe_valid;
            row_reg   <= lav_pkg::ROW_X;
        end else if (m_ready) begin
            row_reg   <= lav_pkg::row_t'(2'(row_reg) + 2'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mat_reg <= pipe_mat;
        end
    end

    always_comb begin
        m_data.row_index  = 2'(row_reg);
        m_data.degenerate = mat_reg.deg;
        m_data.last_row   = (row_reg == lav_pkg::ROW_W);
        case (row_reg)
            lav_pkg::ROW_X: begin
                m_data.elem_0 = mat_reg.x_ax.x;
                m_data.elem_1 = mat_reg.x_ax.y;
                m_data.elem_2 = mat_reg.x_ax.z;
                m_data.elem_3 = mat_reg.tx;
            end
            lav_pkg::ROW_Y: begin
                m_data.elem_0 = mat_reg.y_ax.x;
                m_data.elem_1 = mat_reg.y_ax.y;
                m_data.elem_2 = mat_reg.y_ax.z;
                m_data.elem_3 = mat_reg.ty;
            end
            lav_pkg::ROW_Z: begin
                m_data.elem_0 = mat_reg.z_ax.x;
                m_data.elem_1 = mat_reg.z_ax.y;
                m_data.elem_2 = mat_reg.z_ax.z;
                m_data.elem_3 = mat_reg.tz;
            end
            default: begin
                m_data.elem_0 = '0;
                m_data.elem_1 = '0;
                m_data.elem_2 = '0;
                m_data.elem_3 = one;
            end
        endcase
    end

    assign m_valid = valid_reg;

    a_row_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && m_ready && (row_reg != lav_pkg::ROW_W))
        |=> (2'(row_reg) == 2'($past(2'(row_reg)) + 2'd1)))
        else $error("row counter did not step after a row transaction");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && m_ready && (row_reg == lav_pkg::ROW_W) && !pipe_valid)
        |=> !valid_reg)
        else $error("output still valid after last row with nothing behind it");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |-> valid_reg)
        else $error("pipeline stalled while output stage is empty");

    a_new_matrix_row0: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && pipe_valid) |=> (valid_reg && (row_reg == lav_pkg::ROW_X)))
        else $error("new matrix did not start at row zero");

endmodule

### design/look_at_view_matrix.sv
// Top level of the look-at view matrix pipeline.
//
// Input channel s_*: one transaction carries eye point, target point and up
// direction, all signed fixed point with FRAC_BITS fraction bits. Output
// channel m_*: each input yields four transactions, matrix rows 0..3 in
// order; last_row marks row 3, degenerate is the same on all four rows.
// The datapath is a fully pipelined chain: difference, normalize, cross
// product, normalize, cross product, normalize, translation, row output.
// Each normalization spends one stage per square-root bit (32) and one stage
// per quotient bit (FRAC_BITS+1). Each matrix leaves as four row
// transactions on the output channel; s_ready drops while the output stage
// holds a matrix that has not sent its last row. When m_ready is low and
// the output stage holds a matrix, the whole pipeline holds its contents;
// nothing is dropped or repeated. Reset (aresetn low, synchronous) clears
// all valid bits.
module look_at_view_matrix #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lav_pkg::lav_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output lav_pkg::lav_out_t m_data
);

    localparam int EW  = lav_pkg::ELEM_W;
    localparam int DW0 = EW + 1;
    localparam int CPW = 2 * EW + 1;
    localparam int S1W = $bits(lav_pkg::side1_t);
    localparam int S2W = $bits(lav_pkg::side2_t);
    localparam int S3W = $bits(lav_pkg::side3_t);

    logic                    en;

    logic                    in_valid_reg;
    logic signed [DW0-1:0]   d_reg [3];
    lav_pkg::side1_t         side1_reg;

    logic                    n1_valid;
    lav_pkg::vec3_t          n1_vec;
    logic                    n1_zero;
    logic [S1W-1:0]          n1_side;
    lav_pkg::side1_t         n1_s;
    lav_pkg::side2_t         x1_in_side;
    lav_pkg::elem_t          x1_a [3];
    lav_pkg::elem_t          x1_b [3];

    logic                    x1_valid;
    logic signed [CPW-1:0]   x1_vec [3];
    logic [S2W-1:0]          x1_side;

    logic                    n2_valid;
    lav_pkg::vec3_t          n2_vec;
    logic                    n2_zero;
    logic [S2W-1:0]          n2_side;
    lav_pkg::side2_t         n2_s;
    lav_pkg::side3_t         x2_in_side;
    lav_pkg::elem_t          x2_a [3];
    lav_pkg::elem_t          x2_b [3];

    logic                    x2_valid;
    logic signed [CPW-1:0]   x2_vec [3];
    logic [S3W-1:0]          x2_side;

    logic                    n3_valid;
    lav_pkg::vec3_t          n3_vec;
    logic                    n3_zero;
    logic [S3W-1:0]          n3_side;
    lav_pkg::side3_t         n3_s;
    lav_pkg::axes_t          axes;

    logic                    t_valid;
    lav_pkg::mat_t           t_mat;

    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg[0]       <= DW0'(s_data.eye_x) - DW0'(s_data.target_x);
            d_reg[1]       <= DW0'(s_data.eye_y) - DW0'(s_data.target_y);
            d_reg[2]       <= DW0'(s_data.eye_z) - DW0'(s_data.target_z);
            side1_reg.eye.x <= s_data.eye_x;
            side1_reg.eye.y <= s_data.eye_y;
            side1_reg.eye.z <= s_data.eye_z;
            side1_reg.up.x  <= s_data.upward_x;
            side1_reg.up.y  <= s_data.upward_y;
            side1_reg.up.z  <= s_data.upward_z;
        end
    end

    // z axis from eye minus target.
    lav_norm #(
        .FRAC_BITS (FRAC_BITS),
        .IN_W      (DW0),
        .SIDE_W    (S1W)
    ) u_norm_z (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_valid_reg),
        .in_vec    (d_reg),
        .in_side   (side1_reg),
        .out_valid (n1_valid),
        .out_vec   (n1_vec),
        .out_zero  (n1_zero),
        .out_side  (n1_side)
    );

    assign n1_s           = lav_pkg::side1_t'(n1_side);
    assign x1_a[0]        = n1_s.up.x;
    assign x1_a[1]        = n1_s.up.y;
    assign x1_a[2]        = n1_s.up.z;
    assign x1_b[0]        = n1_vec.x;
    assign x1_b[1]        = n1_vec.y;
    assign x1_b[2]        = n1_vec.z;
    assign x1_in_side.eye  = n1_s.eye;
    assign x1_in_side.z_ax = n1_vec;
    assign x1_in_side.deg  = n1_zero;

    lav_xprod #(
        .A_W       (EW),
        .B_W       (EW),
        .SIDE_W    (S2W)
    ) u_xprod_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (n1_valid),
        .a         (x1_a),
        .b         (x1_b),
        .in_side   (x1_in_side),
        .out_valid (x1_valid),
        .out_vec   (x1_vec),
        .out_side  (x1_side)
    );

    // x axis from up cross z.
    lav_norm #(
        .FRAC_BITS (FRAC_BITS),
        .IN_W      (CPW),
        .SIDE_W    (S2W)
    ) u_norm_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (x1_valid),
        .in_vec    (x1_vec),
        .in_side   (x1_side),
        .out_valid (n2_valid),
        .out_vec   (n2_vec),
        .out_zero  (n2_zero),
        .out_side  (n2_side)
    );

    assign n2_s            = lav_pkg::side2_t'(n2_side);
    assign x2_a[0]         = n2_s.z_ax.x;
    assign x2_a[1]         = n2_s.z_ax.y;
    assign x2_a[2]         = n2_s.z_ax.z;
    assign x2_b[0]         = n2_vec.x;
    assign x2_b[1]         = n2_vec.y;
    assign x2_b[2]         = n2_vec.z;
    assign x2_in_side.eye  = n2_s.eye;
    assign x2_in_side.z_ax = n2_s.z_ax;
    assign x2_in_side.x_ax = n2_vec;
    assign x2_in_side.deg  = n2_s.deg | n2_zero;

    lav_xprod #(
        .A_W       (EW),
        .B_W       (EW),
        .SIDE_W    (S3W)
    ) u_xprod_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (n2_valid),
        .a         (x2_a),
        .b         (x2_b),
        .in_side   (x2_in_side),
        .out_valid (x2_valid),
        .out_vec   (x2_vec),
        .out_side  (x2_side)
    );

    // y axis from z cross x.
    lav_norm #(
        .FRAC_BITS (FRAC_BITS),
        .IN_W      (CPW),
        .SIDE_W    (S3W)
    ) u_norm_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (x2_valid),
        .in_vec    (x2_vec),
        .in_side   (x2_side),
        .out_valid (n3_valid),
        .out_vec   (n3_vec),
        .out_zero  (n3_zero),
        .out_side  (n3_side)
    );

    assign n3_s      = lav_pkg::side3_t'(n3_side);
    assign axes.x_ax = n3_s.x_ax;
    assign axes.y_ax = n3_vec;
    assign axes.z_ax = n3_s.z_ax;
    assign axes.eye  = n3_s.eye;
    assign axes.deg  = n3_s.deg | n3_zero;

    lav_xlate #(
        .FRAC_BITS (FRAC_BITS)
    ) u_xlate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (n3_valid),
        .in_axes   (axes),
        .out_valid (t_valid),
        .out_mat   (t_mat)
    );

    lav_rows #(
        .FRAC_BITS  (FRAC_BITS)
    ) u_rows (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pipe_valid (t_valid),
        .pipe_mat   (t_mat),
        .en         (en),
        .m_valid    (m_valid),
        .m_data     (m_data),
        .m_ready    (m_ready)
    );

endmodule

### bench/look_at_view_matrix_checker.sv
// Checker for the look-at view matrix: predicts the four rows of each matrix and compares them.
`timescale 1ns / 1ps

module look_at_view_matrix_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  lav_pkg::lav_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  lav_pkg::lav_out_t m_data,
    output int                errors,
    output int                rows_pending
);

    localparam int FB = lav_pkg::FRAC_BITS_DEF;

    typedef logic signed [63:0] wide_t;
    typedef logic [2:0][63:0] wvec_t;

    lav_pkg::lav_out_t expected_rows[$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Returns 1 when the vector has zero length; the unit vector is then all zero.
    function automatic logic unit_vec(input wvec_t v, output wvec_t o);
        wvec_t       mg;
        logic [63:0] m;
        logic [63:0] sum;
        logic [63:0] s;
        logic [63:0] q;
        int          len;
        m = '0;
        sum = '0;
        o = '0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = v[i][63] ? -v[i] : v[i];
            if (mg[i] > m) m = mg[i];
        end
        if (m == 0) return 1'b1;
        len = 0;
        while (len < 64 && (m >> len) != 0) len++;
        for (int i = 0; i < 3; i++) begin
            if (len > lav_pkg::NRM_BITS) mg[i] = mg[i] >> (len - lav_pkg::NRM_BITS);
            else if (len < lav_pkg::NRM_BITS) mg[i] = mg[i] << (lav_pkg::NRM_BITS - len);
            sum = sum + mg[i] * mg[i];
        end
        s = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((mg[i] << FB) + (s >> 1)) / s;
            o[i] = v[i][63] ? -q : q;
        end
        return 1'b0;
    endfunction

    function automatic wvec_t cross_prod(input wvec_t a, input wvec_t b);
        wvec_t o;
        o[0] = $signed(a[1]) * $signed(b[2]) - $signed(a[2]) * $signed(b[1]);
        o[1] = $signed(a[2]) * $signed(b[0]) - $signed(a[0]) * $signed(b[2]);
        o[2] = $signed(a[0]) * $signed(b[1]) - $signed(a[1]) * $signed(b[0]);
        return o;
    endfunction

    // Negated dot product, rounded half away from zero and saturated to 32 bits.
    function automatic lav_pkg::elem_t translate(input wvec_t ax, input wvec_t eye);
        wide_t dot;
        wide_t mag;
        wide_t r;
        wide_t t;
        dot = $signed(ax[0]) * $signed(eye[0]) + $signed(ax[1]) * $signed(eye[1])
            + $signed(ax[2]) * $signed(eye[2]);
        mag = dot < 0 ? -dot : dot;
        r = (mag + (64'sd1 <<< (FB - 1))) >>> FB;
        t = dot < 0 ? r : -r;
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        if (t < -64'sd2147483648) t = -64'sd2147483648;
        return lav_pkg::elem_t'(t[31:0]);
    endfunction

    task automatic predict_view(input lav_pkg::lav_in_t v);
        wvec_t             eye;
        wvec_t             up;
        wvec_t             d;
        wvec_t             ax[3];
        logic              deg;
        lav_pkg::lav_out_t row;
        eye[0] = 64'($signed(v.eye_x));
        eye[1] = 64'($signed(v.eye_y));
        eye[2] = 64'($signed(v.eye_z));
        up[0] = 64'($signed(v.upward_x));
        up[1] = 64'($signed(v.upward_y));
        up[2] = 64'($signed(v.upward_z));
        d[0] = $signed(eye[0]) - 64'($signed(v.target_x));
        d[1] = $signed(eye[1]) - 64'($signed(v.target_y));
        d[2] = $signed(eye[2]) - 64'($signed(v.target_z));
        deg = unit_vec(d, ax[2]);
        deg = unit_vec(cross_prod(up, ax[2]), ax[0]) | deg;
        deg = unit_vec(cross_prod(ax[2], ax[0]), ax[1]) | deg;
        for (int r = 0; r < 3; r++) begin
            row.elem_0 = ax[r][0][31:0];
            row.elem_1 = ax[r][1][31:0];
            row.elem_2 = ax[r][2][31:0];
            row.elem_3 = translate(ax[r], eye);
            row.row_index = 2'(r);
            row.degenerate = deg;
            row.last_row = 1'b0;
            expected_rows.push_back(row);
        end
        row.elem_0 = '0;
        row.elem_1 = '0;
        row.elem_2 = '0;
        row.elem_3 = 32'sd1 <<< FB;
        row.row_index = lav_pkg::ROW_W;
        row.degenerate = deg;
        row.last_row = 1'b1;
        expected_rows.push_back(row);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    initial errors = 0;

    always @(posedge aclk) begin
        lav_pkg::lav_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) predict_view(s_data);
            if (m_valid && m_ready) begin
                if (expected_rows.size() == 0) begin
                    $error("row transaction with no matrix row outstanding");
                    errors++;
                end else begin
                    want = expected_rows.pop_front();
                    check_field("elem_0", want.elem_0, m_data.elem_0);
                    check_field("elem_1", want.elem_1, m_data.elem_1);
                    check_field("elem_2", want.elem_2, m_data.elem_2);
                    check_field("elem_3", want.elem_3, m_data.elem_3);
                    check_field("row_index", 32'(want.row_index), 32'(m_data.row_index));
                    check_field("degenerate", 32'(want.degenerate), 32'(m_data.degenerate));
                    check_field("last_row", 32'(want.last_row), 32'(m_data.last_row));
                end
            end
        end
        rows_pending <= expected_rows.size();
    end

endmodule

### bench/look_at_view_matrix_tb.sv
// Testbench top for the look-at view matrix: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module look_at_view_matrix_tb;

    localparam int LATENCY = 3 * lav_pkg::FRAC_BITS_DEF + 132;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 250;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    lav_pkg::lav_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    lav_pkg::lav_out_t m_data;
    int                errors;
    int                rows_pending;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                cycle_count;

    look_at_view_matrix dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    look_at_view_matrix_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .errors(errors), .rows_pending(rows_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("look_at_view_matrix_tb: errors");
            $finish;
        end
    end

    // Holds valid and payload steady until the transaction is taken.
    task automatic send_view(input lav_pkg::lav_in_t v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic lav_pkg::elem_t rand_elem(input int mode);
        case (mode)
            0: return lav_pkg::elem_t'($urandom);
            1: return lav_pkg::elem_t'($signed($urandom_range(131072)) - 65536);
            2: return lav_pkg::elem_t'($signed($urandom_range(4096)) - 2048);
            default: return lav_pkg::elem_t'($urandom_range(3) == 0 ? 32'h8000_0000
                                                                    : 32'h7fff_ffff);
        endcase
    endfunction

    function automatic lav_pkg::lav_in_t rand_view();
        lav_pkg::lav_in_t v;
        int               mode;
        mode = $urandom_range(9);
        v.eye_x = rand_elem(mode % 3);
        v.eye_y = rand_elem(mode % 3);
        v.eye_z = rand_elem(mode % 3);
        v.target_x = rand_elem($urandom_range(2));
        v.target_y = rand_elem($urandom_range(2));
        v.target_z = rand_elem($urandom_range(2));
        v.upward_x = rand_elem($urandom_range(2));
        v.upward_y = rand_elem($urandom_range(2));
        v.upward_z = rand_elem($urandom_range(2));
        // Now and then make the view direction collapse or line up with up, or make up zero.
        if (mode == 8) begin
            v.target_x = v.eye_x;
            v.target_y = v.eye_y;
            v.target_z = v.eye_z;
        end else if (mode == 9) begin
            v.upward_x = v.eye_x - v.target_x;
            v.upward_y = v.eye_y - v.target_y;
            v.upward_z = v.eye_z - v.target_z;
        end else if (mode == 7) begin
            v.upward_x = '0;
            v.upward_y = '0;
            v.upward_z = '0;
        end
        if ($urandom_range(15) == 0) v.eye_x = rand_elem(3);
        return v;
    endfunction

    function automatic lav_pkg::lav_in_t make_view(input lav_pkg::elem_t ex, ey, ez,
                                                   tx, ty, tz, ux, uy, uz);
        lav_pkg::lav_in_t v;
        v = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
        return v;
    endfunction

    localparam lav_pkg::elem_t ONE = 32'sd65536;
    localparam lav_pkg::elem_t MAXV = 32'sh7fff_ffff;
    localparam lav_pkg::elem_t MINV = 32'sh8000_0000;

    initial begin
        cycle_count = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        send_idle_pct = 23;
        recv_idle_pct = 74;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed views: ordinary, degenerate and saturating cases.
        send_view(make_view(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0));
        send_view(make_view(ONE, 2 * ONE, 3 * ONE, -ONE, 0, ONE, 0, ONE, 0));
        send_view('0);
        send_view(make_view(ONE, ONE, ONE, ONE, ONE, ONE, 0, ONE, 0));
        send_view(make_view(0, 5 * ONE, 0, 0, 0, 0, 0, ONE, 0));
        send_view(make_view(0, 0, ONE, 0, 0, 0, 0, 0, 0));
        send_view(make_view(MAXV, MAXV, MAXV, MINV, MINV, MINV, 0, ONE, 0));
        send_view(make_view(MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, MAXV));
        send_view(make_view(MAXV, 0, 0, 0, 0, 0, 0, ONE, 0));
        send_view(make_view(MINV, 0, 0, 0, 0, 0, 0, 0, ONE));
        send_view(make_view(0, MAXV, MINV, 0, 0, 0, MINV, 0, 0));
        send_view(make_view(1, 0, 0, 0, 0, 0, 0, 0, 1));
        send_view(make_view(-1, -1, -1, 0, 0, 0, MINV, MINV, MINV));
        send_view(make_view(MAXV, MAXV, MAXV, 0, 0, 0, 0, 0, 0));
        s_valid = 1'b0;

        // Let the pipeline drain completely before the random part.
        while (rows_pending != 0) @(negedge aclk);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_idle_pct = 74;
                recv_idle_pct = 23;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_view(rand_view());
        end
        s_valid = 1'b0;

        while (rows_pending != 0) @(negedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        if (errors == 0) begin
            $display("look_at_view_matrix_tb: clean");
        end else begin
            $display("look_at_view_matrix_tb: errors");
        end
        $finish;
    end

endmodule

### filelist.f
design/lav_pkg.sv
design/lav_norm.sv
design/lav_xprod.sv
design/lav_xlate.sv
design/lav_rows.sv
design/look_at_view_matrix.sv
bench/look_at_view_matrix_checker.sv
bench/look_at_view_matrix_tb.sv
